// ===== hw/rtl/ordered_list_engine_defines.svh =====
// Assertion macros used by the checker file of ordered_list_engine.
// No dependencies; the including module must have clk_i and rst_ni in scope.
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ole_pkg.sv =====
// Types and constants of the ordered list engine: opcodes, status codes, item structs.
// No dependencies.
package ole_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IndexW = 7;
  localparam int unsigned CountW = 7;
  localparam int unsigned FoundW = 6;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_FIND      = 3'd6,
    OP_READ      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic signed [DataW-1:0]  value;
    logic [IndexW-1:0]        index;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  result_value;
    logic [FoundW-1:0]        found_index;
    logic [CountW-1:0]        count;
    logic                     empty_res;
  } out_item_t;

endpackage

// ===== hw/rtl/ordered_list_engine.sv =====
// Ordered list engine: a list of signed values in one synchronous memory.
// Depends on ole_pkg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------
//   in      | input     | in_valid_i/in_ready_o | in_item_t
//   out     | output    | out_valid_o/out_ready_i | out_item_t
//
// One item at a time. A rejected request goes from S_IDLE to S_DONE, an insert at the
// back writes in S_WRITE, a read, remove or find scans its entries in S_SCAN and then
// passes S_DRAIN, and a shifting insert adds S_WRITE after that; the scan moves one
// entry per cycle through the separate read and write ports. Reset empties the list
// at once, no clearing pass.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a later result waits for that register to free up.
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > IndexW) ? LW : IndexW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [DataW-1:0]  val_q, val_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     scan_q, scan_d;
  logic [AW-1:0]     end_q, end_d;
  logic [LW-1:0]     len_q, len_d;
  status_e           status_q, status_d;
  logic [DataW-1:0]  rv_q, rv_d;
  logic [AW-1:0]     fi_q, fi_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // memory and its ports
  logic [DataW-1:0]  entries_q [CAPACITY];
  logic [DataW-1:0]  rd_data_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DataW-1:0]  mem_wdata;

  // request decode
  logic              req_ins, req_rem, req_find, req_read, req_ok;
  logic [CW-1:0]     len_c, req_pos;
  status_e           req_status;
  logic              cur_ins, cur_rem;
  logic [LW-1:0]     new_len;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // classify the incoming request and check it against the current length
  always_comb begin
    len_c    = CW'(len_q);
    req_ins  = 1'b0;
    req_rem  = 1'b0;
    req_find = 1'b0;
    req_read = 1'b0;
    req_pos  = '0;
    case (in_item_i.op)
      OP_INS_FRONT: begin req_ins = 1'b1; req_pos = '0; end
      OP_INS_BACK:  begin req_ins = 1'b1; req_pos = len_c; end
      OP_INS_AT:    begin req_ins = 1'b1; req_pos = CW'(in_item_i.index); end
      OP_REM_FRONT: begin req_rem = 1'b1; req_pos = '0; end
      OP_REM_BACK:  begin req_rem = 1'b1; req_pos = len_c - CW'(1); end
      OP_REM_AT:    begin req_rem = 1'b1; req_pos = CW'(in_item_i.index); end
      OP_FIND:      begin req_find = 1'b1; req_pos = '0; end
      default:      begin req_read = 1'b1; req_pos = CW'(in_item_i.index); end
    endcase

    if (req_ins) begin
      if (len_c >= CW'(CAPACITY))   req_status = ST_FULL;
      else if (req_pos > len_c)     req_status = ST_RANGE;
      else                          req_status = ST_OK;
    end else if (req_find) begin
      req_status = (len_q == '0) ? ST_EMPTY : ST_NOTFOUND;
    end else begin
      if (len_q == '0)              req_status = ST_EMPTY;
      else if (req_pos >= len_c)    req_status = ST_RANGE;
      else                          req_status = ST_OK;
    end
    req_ok = (req_status == ST_OK) || (req_find && (req_status == ST_NOTFOUND));
  end

  // class of the request in flight and the length it leaves behind
  always_comb begin
    cur_ins = (op_q == OP_INS_FRONT) || (op_q == OP_INS_BACK) || (op_q == OP_INS_AT);
    cur_rem = (op_q == OP_REM_FRONT) || (op_q == OP_REM_BACK) || (op_q == OP_REM_AT);
    new_len = len_q;
    if (status_q == ST_OK) begin
      if (cur_ins)      new_len = len_q + LW'(1);
      else if (cur_rem) new_len = len_q - LW'(1);
    end
  end

  // sequencer: scan issues one read per cycle, returning data is handled in the
  // cycle after. Shift-up reads i while writing i+2, shift-down reads i while
  // writing i-2, so the read and write ports never meet on one entry.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    end_d       = end_q;
    len_d       = len_q;
    status_d    = status_q;
    rv_d        = rv_q;
    fi_d        = fi_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = val_q;
    mem_re      = 1'b0;
    mem_raddr   = scan_q;

    // handle data returned by the previous read
    if (rd_vld_q) begin
      if (cur_ins) begin
        mem_we    = 1'b1;
        mem_waddr = rd_idx_q + AW'(1);
        mem_wdata = rd_data_q;
      end else if (op_q == OP_FIND) begin
        if ((status_q == ST_NOTFOUND) && (rd_data_q == val_q)) begin
          status_d = ST_OK;
          fi_d     = rd_idx_q;
        end
      end else if (rd_idx_q == pos_q) begin
        rv_d = rd_data_q;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = rd_idx_q - AW'(1);
        mem_wdata = rd_data_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_item_i.op;
          val_d    = in_item_i.value;
          pos_d    = AW'(req_pos);
          status_d = req_status;
          rv_d     = '0;
          fi_d     = '0;
          if (!req_ok) begin
            state_d = S_DONE;
          end else if (req_ins) begin
            if (req_pos == len_c) begin
              state_d = S_WRITE;
            end else begin
              scan_d  = AW'(len_c - CW'(1));
              end_d   = AW'(req_pos);
              state_d = S_SCAN;
            end
          end else if (req_rem) begin
            scan_d  = AW'(req_pos);
            end_d   = AW'(len_c - CW'(1));
            state_d = S_SCAN;
          end else if (req_read) begin
            scan_d  = AW'(req_pos);
            end_d   = AW'(req_pos);
            state_d = S_SCAN;
          end else begin
            scan_d  = '0;
            end_d   = AW'(len_c - CW'(1));
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_q;
        rd_vld_d  = 1'b1;
        rd_idx_d  = scan_q;
        if (scan_q == end_q) begin
          state_d = S_DRAIN;
        end else if (cur_ins) begin
          scan_d = scan_q - AW'(1);
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      S_DRAIN: begin
        state_d = cur_ins ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status       = status_q;
          out_d.result_value = rv_q;
          out_d.found_index  = FoundW'(fi_q);
          out_d.count        = CountW'(new_len);
          out_d.empty_res    = (new_len == '0);
          out_valid_d        = 1'b1;
          len_d              = new_len;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= OP_INS_FRONT;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      status_q    <= status_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    pos_q    <= pos_d;
    scan_q   <= scan_d;
    end_q    <= end_d;
    rv_q     <= rv_d;
    fi_q     <= fi_d;
    rd_idx_q <= rd_idx_d;
    out_q    <= out_d;
  end

  // list storage: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entries_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= entries_q[mem_raddr];
    end
  end

endmodule

// ===== hw/rtl/ole_chk.sv =====
// Port-level checker for ordered_list_engine, attached by bind.
// Depends on ole_pkg and ordered_list_engine_defines.svh.
`include "ordered_list_engine_defines.svh"

module ole_chk
  import ole_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a pending result holds until taken
  `OLE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_item_o), "result changed while stalled")

  // one item in flight: ready drops right after an accept
  `OLE_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o,
                   "second item accepted while busy")

  // empty flag agrees with the count
  `OLE_ASSERT_NOW(a_empty_flag, out_valid_o,
                  out_item_o.empty_res == (out_item_o.count == '0), "empty flag and count disagree")

  // count never exceeds the capacity
  `OLE_ASSERT_NOW(a_count_cap, out_valid_o, out_item_o.count <= CAPACITY, "count above capacity")

  // a failed request reports zero value and index
  `OLE_ASSERT_NOW(a_fail_zero, out_valid_o && (out_item_o.status != ST_OK),
                  (out_item_o.result_value == '0) && (out_item_o.found_index == '0),
                  "failed request carries data")

endmodule

bind ordered_list_engine ole_chk #(.CAPACITY(CAPACITY)) u_ole_chk (.*);
